[sv/r2fft_pkg.sv]
package r2fft_pkg;

  localparam int unsigned POINTS_DEF       = 1024;
  localparam int unsigned TWIDDLE_BITS_DEF = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_COPY_RD,
    S_COPY_WR,
    S_BF_E,
    S_BF_O,
    S_BF_MUL,
    S_BF_SUM,
    S_BF_WE,
    S_BF_WO
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic emit_rd;
    logic out_load;
    logic copy_rd;
    logic copy_wr;
    logic bf_rd_e;
    logic bf_rd_o;
    logic bf_mul;
    logic bf_sum;
    logic bf_wr_e;
    logic bf_wr_o;
    logic xf_done;
  } cmd_t;

  typedef struct packed {
    logic emit_avail;
    logic frame_end;
    logic copy_last;
    logic bf_last;
    logic stage_last;
    logic out_busy;
  } status_t;

  // Q30 Taylor series sin/cos after reduction to [0, pi/4]; returns {cos, sin}
  // already rounded to frac fraction bits, cos signed.
  function automatic logic [63:0] tw_pair(input int unsigned k, input int unsigned lg,
                                          input int unsigned frac);
    longint unsigned th, x, x2, tc, ts;
    longint          sc, ss, c, s, t, lim;
    bit              neg_c, swap;
    th    = (64'd6746518852 * longint'(k)) >> lg;
    neg_c = 1'b0;
    swap  = 1'b0;
    if (th > 64'd1686629713) begin
      th    = (th < 64'd3373259426) ? 64'd3373259426 - th : 64'd0;
      neg_c = 1'b1;
    end
    if (th > 64'd843314857) begin
      th   = 64'd1686629713 - th;
      swap = 1'b1;
    end
    x  = th;
    x2 = (x * x) >> 30;
    tc = 64'd1073741824;
    ts = x;
    sc = 64'sd1073741824;
    ss = longint'(x);
    tc = ((tc * x2) >> 30) / 2;   ts = ((ts * x2) >> 30) / 6;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 12;  ts = ((ts * x2) >> 30) / 20;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 30;  ts = ((ts * x2) >> 30) / 42;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 56;  ts = ((ts * x2) >> 30) / 72;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 90;  ts = ((ts * x2) >> 30) / 110;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 132; ts = ((ts * x2) >> 30) / 156;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 182; ts = ((ts * x2) >> 30) / 210;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    if (swap) begin
      t  = sc;
      sc = ss;
      ss = t;
    end
    lim = (64'sd1 <<< frac) - 1;
    if (sc < 0) sc = 0;
    if (ss < 0) ss = 0;
    c = (sc + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    s = (ss + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    if (c > lim) c = lim;
    if (s > lim) s = lim;
    if (neg_c) c = -c;
    return {c[31:0], s[31:0]};
  endfunction

endpackage

[sv/r2fft_ram.sv]
module r2fft_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/r2fft_dp.sv]
module r2fft_dp #(
  parameter int unsigned POINTS       = r2fft_pkg::POINTS_DEF,
  parameter int unsigned TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  r2fft_pkg::cmd_t     cmd_i,
  output r2fft_pkg::status_t  status_o,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic [31:0]         s_data_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [63:0]         m_data_o,
  output logic [11:0]         m_user_o,
  output logic                m_last_o
);
  import r2fft_pkg::*;

  localparam int unsigned LG    = $clog2(POINTS);
  localparam int unsigned F     = TWIDDLE_BITS - 1;
  localparam int unsigned TW    = TWIDDLE_BITS;
  localparam int unsigned TW_AW = (LG > 1) ? LG - 1 : 1;
  localparam int unsigned SW    = (LG > 1) ? $clog2(LG) : 1;
  localparam int unsigned PW    = 32 + TW;

  typedef logic [2*TW-1:0] rom_t [1 << TW_AW];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] p;
    for (int k = 0; k < (1 << TW_AW); k++) begin
      p    = tw_pair(k, LG, F);
      r[k] = {p[32 +: TW], p[0 +: TW]};
    end
    return r;
  endfunction

  localparam rom_t TW_ROM = build_rom();

  logic              mode_q, xf_inv_q, out_inv_q, ready_q;
  logic [LG-1:0]     load_cnt_q, cnt_q, out_idx_q;
  logic [LG:0]       emit_cnt_q;
  logic [SW-1:0]     stage_q;
  logic [LG-1:0]     half, j, e_addr, o_addr, w_full, rev_addr;
  logic [31:0]       ld_rdata;
  logic [63:0]       wk_rdata, wk_wdata;
  logic              wk_we;
  logic [LG-1:0]     wk_waddr, wk_raddr;
  logic signed [TW-1:0] tw_c_q, tw_s_q;
  logic signed [31:0]   ev_re_q, ev_im_q;
  logic signed [PW-1:0] p_cr_q, p_si_q, p_ci_q, p_sr_q;
  logic signed [PW:0]   sum_r, sum_i;
  logic [31:0]       t_re_q, t_im_q;
  logic              m_valid_q, m_last_q;
  logic [63:0]       m_data_q;
  logic [31:0]       out_re, out_im, neg_im;
  logic signed [32:0] sc_re, sc_im;
  logic signed [31:0] ld_im_ext;

  assign status_o.emit_avail = ready_q && (emit_cnt_q != (LG+1)'(POINTS));
  assign status_o.frame_end  = (load_cnt_q == LG'(POINTS - 1));
  assign status_o.copy_last  = (cnt_q == LG'(POINTS - 1));
  assign status_o.bf_last    = (cnt_q == LG'(POINTS / 2 - 1));
  assign status_o.stage_last = (stage_q == SW'(LG - 1));
  assign status_o.out_busy   = m_valid_q;

  // butterfly addressing for stage s: span 2^(s+1), twiddle step N >> (s+1)
  always_comb begin
    half   = LG'(1) << stage_q;
    j      = cnt_q & (half - LG'(1));
    e_addr = (((cnt_q >> stage_q) << stage_q) << 1) | j;
    o_addr = e_addr | half;
    w_full = j << (LG'(LG - 1) - LG'(stage_q));
    for (int b = 0; b < LG; b++) begin
      rev_addr[b] = cnt_q[LG-1-b];
    end
  end

  r2fft_ram #(.WIDTH(32), .DEPTH(POINTS)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (load_cnt_q),
    .wdata_i (s_data_i),
    .raddr_i (rev_addr),
    .rdata_o (ld_rdata)
  );

  always_comb begin
    ld_im_ext = 32'(signed'(ld_rdata[31:16]));
    sum_r     = $signed(p_cr_q) + $signed(p_si_q) + $signed((PW+1)'(1 << (F - 1)));
    sum_i     = $signed(p_ci_q) - $signed(p_sr_q) + $signed((PW+1)'(1 << (F - 1)));
    wk_we     = cmd_i.copy_wr | cmd_i.bf_wr_e | cmd_i.bf_wr_o;
    wk_waddr  = cmd_i.copy_wr ? cnt_q : (cmd_i.bf_wr_o ? o_addr : e_addr);
    wk_raddr  = cmd_i.emit_rd ? emit_cnt_q[LG-1:0] : (cmd_i.bf_rd_o ? o_addr : e_addr);
    if (cmd_i.copy_wr) begin
      wk_wdata = {xf_inv_q ? -ld_im_ext : ld_im_ext, 32'(signed'(ld_rdata[15:0]))};
    end else if (cmd_i.bf_wr_o) begin
      wk_wdata = {ev_im_q - t_im_q, ev_re_q - t_re_q};
    end else begin
      wk_wdata = {ev_im_q + t_im_q, ev_re_q + t_re_q};
    end
  end

  r2fft_ram #(.WIDTH(64), .DEPTH(POINTS)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wk_we),
    .waddr_i (wk_waddr),
    .wdata_i (wk_wdata),
    .raddr_i (wk_raddr),
    .rdata_o (wk_rdata)
  );

  // inverse: conjugate again and scale by 1/N, round half up
  always_comb begin
    neg_im = -wk_rdata[63:32];
    sc_re  = ($signed({wk_rdata[31], wk_rdata[31:0]}) + $signed(33'(1 << (LG - 1)))) >>> LG;
    sc_im  = ($signed({neg_im[31], neg_im}) + $signed(33'(1 << (LG - 1)))) >>> LG;
    out_re = out_inv_q ? sc_re[31:0] : wk_rdata[31:0];
    out_im = out_inv_q ? sc_im[31:0] : wk_rdata[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      xf_inv_q   <= 1'b0;
      out_inv_q  <= 1'b0;
      ready_q    <= 1'b0;
      load_cnt_q <= '0;
      emit_cnt_q <= '0;
      cnt_q      <= '0;
      stage_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        mode_q <= cfg_wr_data_i;
      end
      if (cmd_i.load_wr) begin
        load_cnt_q <= load_cnt_q + LG'(1);
        if (status_o.frame_end) begin
          xf_inv_q <= mode_q;
        end
      end
      if (cmd_i.emit_rd) begin
        emit_cnt_q <= emit_cnt_q + (LG+1)'(1);
      end
      if (cmd_i.copy_wr) begin
        cnt_q <= cnt_q + LG'(1);
      end
      if (cmd_i.bf_wr_o) begin
        if (status_o.bf_last) begin
          cnt_q   <= '0;
          stage_q <= status_o.stage_last ? '0 : stage_q + SW'(1);
        end else begin
          cnt_q <= cnt_q + LG'(1);
        end
      end
      if (cmd_i.xf_done) begin
        ready_q    <= 1'b1;
        emit_cnt_q <= '0;
        out_inv_q  <= xf_inv_q;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) begin
      out_idx_q <= emit_cnt_q[LG-1:0];
    end
    if (cmd_i.out_load) begin
      m_data_q <= {out_im, out_re};
      m_last_q <= (out_idx_q == LG'(POINTS - 1));
    end
    if (cmd_i.bf_rd_e) begin
      {tw_c_q, tw_s_q} <= TW_ROM[w_full[TW_AW-1:0]];
    end
    if (cmd_i.bf_rd_o) begin
      ev_re_q <= wk_rdata[31:0];
      ev_im_q <= wk_rdata[63:32];
    end
    if (cmd_i.bf_mul) begin
      p_cr_q <= tw_c_q * $signed(wk_rdata[31:0]);
      p_si_q <= tw_s_q * $signed(wk_rdata[63:32]);
      p_ci_q <= tw_c_q * $signed(wk_rdata[63:32]);
      p_sr_q <= tw_s_q * $signed(wk_rdata[31:0]);
    end
    if (cmd_i.bf_sum) begin
      t_re_q <= 32'(sum_r >>> F);
      t_im_q <= 32'(sum_i >>> F);
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = 12'(out_idx_q);
  assign m_last_o  = m_last_q;

endmodule

[sv/r2fft_ctrl.sv]
module r2fft_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  r2fft_pkg::status_t status_i,
  output r2fft_pkg::cmd_t    cmd_o
);
  import r2fft_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   acc;

  assign s_ready_o = (state_q == S_IDLE) && !status_i.out_busy;
  assign acc       = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (status_i.emit_avail) begin
            state_d = S_EMIT;
            pend_d  = status_i.frame_end;
          end else if (status_i.frame_end) begin
            state_d = S_COPY_RD;
          end
        end
      end
      S_EMIT: begin
        state_d = pend_q ? S_COPY_RD : S_IDLE;
        pend_d  = 1'b0;
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: state_d = status_i.copy_last ? S_BF_E : S_COPY_RD;
      S_BF_E:    state_d = S_BF_O;
      S_BF_O:    state_d = S_BF_MUL;
      S_BF_MUL:  state_d = S_BF_SUM;
      S_BF_SUM:  state_d = S_BF_WE;
      S_BF_WE:   state_d = S_BF_WO;
      S_BF_WO:   state_d = (status_i.bf_last && status_i.stage_last) ? S_IDLE : S_BF_E;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_wr  = acc;
    cmd_o.emit_rd  = acc && status_i.emit_avail;
    case (state_q)
      S_EMIT:    cmd_o.out_load = 1'b1;
      S_COPY_RD: cmd_o.copy_rd  = 1'b1;
      S_COPY_WR: cmd_o.copy_wr  = 1'b1;
      S_BF_E:    cmd_o.bf_rd_e  = 1'b1;
      S_BF_O:    cmd_o.bf_rd_o  = 1'b1;
      S_BF_MUL:  cmd_o.bf_mul   = 1'b1;
      S_BF_SUM:  cmd_o.bf_sum   = 1'b1;
      S_BF_WE:   cmd_o.bf_wr_e  = 1'b1;
      S_BF_WO: begin
        cmd_o.bf_wr_o = 1'b1;
        cmd_o.xf_done = status_i.bf_last && status_i.stage_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  a_emit_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_rd |=> state_q == S_EMIT)
    else $error("emit read not followed by output load");
  a_frame_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && status_i.frame_end && !status_i.emit_avail |=> state_q == S_COPY_RD)
    else $error("full frame did not start the transform");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.xf_done |=> state_q == S_IDLE)
    else $error("transform end did not return to idle");

endmodule

[sv/radix2_fft_ifft_frame.sv]
// Output: an accepted input reads the next bin from the work RAM; the emit state registers it
// into the output register, which then offers it. Throughput: 1 transaction per cycle while the
// first frame loads; while bins are drained, no new sample is taken until the bin drained by the
// previous one has been taken. The last sample of a frame starts a transform (bit-reverse copy,
// then one shared butterfly over the work RAM, after an emit state when a bin goes out first).
// No input is taken during the transform. Reset (async, active low) clears counters, mode and the frame-ready flag.
module radix2_fft_ifft_frame #(
  parameter int unsigned POINTS       = r2fft_pkg::POINTS_DEF,
  parameter int unsigned TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,   // inverse_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // sample_re[15:0], sample_im[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // bin_re[31:0], bin_im[63:32]
  output logic [11:0] m_axis_tuser,    // bin_index[11:0]
  output logic        m_axis_tlast
);
  import r2fft_pkg::*;

  cmd_t    cmd;
  status_t status;

  r2fft_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  r2fft_dp #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_data_i      (s_axis_tdata),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata),
    .m_user_o      (m_axis_tuser),
    .m_last_o      (m_axis_tlast)
  );

endmodule

[sim/fft_frame_checker.sv]
module fft_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [11:0] m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          bins_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N    = r2fft_pkg::POINTS_DEF;
  localparam int FB   = r2fft_pkg::TWIDDLE_BITS_DEF - 1;
  localparam int LG_N = $clog2(N);

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [11:0]        idx;
    logic               last;
  } bin_t;

  longint          cos_tab[N/2];
  longint          sin_tab[N/2];
  shortint         frame_re[N];
  shortint         frame_im[N];
  int              spec_re[N];
  int              spec_im[N];
  int              load_cnt;
  int              emit_cnt;
  bit              spec_valid;
  bit              inv_mode;
  bin_t            bins_q[$];

  // floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic void q30_sincos(input longint unsigned x, output longint cs,
                                     output longint sn);
    longint unsigned x2, tc, ts;
    x2 = (x * x) >> 30;
    tc = 64'd1073741824;
    ts = x;
    cs = 64'sd1073741824;
    sn = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
      ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2) begin
        cs -= longint'(tc);
        sn -= longint'(ts);
      end else begin
        cs += longint'(tc);
        sn += longint'(ts);
      end
    end
  endfunction

  function automatic longint to_q15(input longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
    return (r > (64'sd1 <<< FB) - 1) ? (64'sd1 <<< FB) - 1 : r;
  endfunction

  initial begin
    longint unsigned th;
    longint c, s, t;
    bit neg_c, swap;
    for (int k = 0; k < N / 2; k++) begin
      th = (64'd6746518852 * longint'(k)) / N;
      neg_c = 0;
      swap = 0;
      if (th > 64'd1686629713) begin
        th = (th < 64'd3373259426) ? 64'd3373259426 - th : 64'd0;
        neg_c = 1;
      end
      if (th > 64'd843314857) begin
        th = 64'd1686629713 - th;
        swap = 1;
      end
      q30_sincos(th, c, s);
      if (swap) begin
        t = c;
        c = s;
        s = t;
      end
      cos_tab[k] = neg_c ? -to_q15(c) : to_q15(c);
      sin_tab[k] = to_q15(s);
    end
  end

  task automatic run_transform();
    int r, hf, e, o, w;
    longint tr, ti, er, ei;
    for (int i = 0; i < N; i++) begin
      r = 0;
      for (int b = 0; b < LG_N; b++) r = (r << 1) | ((i >> b) & 1);
      spec_re[i] = frame_re[r];
      spec_im[i] = inv_mode ? -int'(frame_im[r]) : int'(frame_im[r]);
    end
    for (int len = 2; len <= N; len *= 2) begin
      hf = len / 2;
      for (int base = 0; base < N; base += len) begin
        for (int j = 0; j < hf; j++) begin
          w = j * (N / len);
          e = base + j;
          o = e + hf;
          tr = rnd_shift(cos_tab[w] * spec_re[o] + sin_tab[w] * spec_im[o], FB);
          ti = rnd_shift(cos_tab[w] * spec_im[o] - sin_tab[w] * spec_re[o], FB);
          er = spec_re[e];
          ei = spec_im[e];
          spec_re[e] = int'(er + tr);
          spec_im[e] = int'(ei + ti);
          spec_re[o] = int'(er - tr);
          spec_im[o] = int'(ei - ti);
        end
      end
    end
    if (inv_mode) begin
      for (int i = 0; i < N; i++) begin
        spec_re[i] = int'(rnd_shift(spec_re[i], LG_N));
        spec_im[i] = int'(rnd_shift(longint'(-spec_im[i]), LG_N));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t want;
    if (!rst_ni) begin
      load_cnt   = 0;
      emit_cnt   = 0;
      spec_valid = 0;
      inv_mode   = 0;
      fail_cnt_o = 0;
      bins_q.delete();
    end else begin
      if (cfg_wr_en_i) inv_mode = cfg_wr_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (bins_q.size() == 0) begin
          $error("unexpected bin transaction: index %0d", m_axis_tuser);
          fail_cnt_o++;
        end else begin
          want = bins_q.pop_front();
          if (m_axis_tdata[31:0] !== want.re) begin
            $error("bin_re: expected %0d, got %0d", want.re, $signed(m_axis_tdata[31:0]));
            fail_cnt_o++;
          end
          if (m_axis_tdata[63:32] !== want.im) begin
            $error("bin_im: expected %0d, got %0d", want.im, $signed(m_axis_tdata[63:32]));
            fail_cnt_o++;
          end
          if (m_axis_tuser !== want.idx) begin
            $error("bin_index: expected %0d, got %0d", want.idx, m_axis_tuser);
            fail_cnt_o++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (spec_valid && emit_cnt < N) begin
          want.re   = spec_re[emit_cnt];
          want.im   = spec_im[emit_cnt];
          want.idx  = emit_cnt[11:0];
          want.last = (emit_cnt == N - 1);
          bins_q.insert(bins_q.size(), want);
          emit_cnt++;
        end
        frame_re[load_cnt] = s_axis_tdata[15:0];
        frame_im[load_cnt] = s_axis_tdata[31:16];
        load_cnt++;
        if (load_cnt == N) begin
          run_transform();
          load_cnt   = 0;
          emit_cnt   = 0;
          spec_valid = 1;
        end
      end
    end
    bins_pending_o = bins_q.size();
  end

endmodule

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SAMPLES = 1700;
  localparam int MAX_CYCLES  = 1000000;
  localparam int XFORM_WAIT  = 40000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_wr_en = 0;
  logic        cfg_wr_data = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [11:0] m_tuser;
  logic        m_tlast;
  int          fail_cnt;
  int          bins_pending;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          sent = 0;
  bit          rcv_hold = 0;
  int          cycles = 0;
  logic [15:0] edge_vals [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                 16'h0001, 16'h5555, 16'haaaa, 16'h8001};

  radix2_fft_ifft_frame i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  fft_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .s_axis_tvalid  (s_tvalid),
    .s_axis_tready  (s_tready),
    .s_axis_tdata   (s_tdata),
    .m_axis_tvalid  (m_tvalid),
    .m_axis_tready  (m_tready),
    .m_axis_tdata   (m_tdata),
    .m_axis_tuser   (m_tuser),
    .m_axis_tlast   (m_tlast),
    .fail_cnt_o     (fail_cnt),
    .bins_pending_o (bins_pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
  end

  // long receiver hold while frame two loads: output backs up, input stalls
  initial begin
    wait (sent >= 1300);
    rcv_hold = 1;
    repeat (3000) @(posedge clk_i);
    rcv_hold = 0;
  end

  task automatic put_sample(input logic [15:0] re, input logic [15:0] im);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 0;
      @(negedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata  <= {im, re};
    do @(posedge clk_i); while (!s_tready);
    sent++;
    @(negedge clk_i);
  endtask

  // mode register only written with nothing in flight
  task automatic set_mode(input logic inv, input int settle);
    s_tvalid <= 0;
    wait (bins_pending == 0);
    @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
    cfg_wr_en   <= 1;
    cfg_wr_data <= inv;
    @(negedge clk_i);
    cfg_wr_en <= 0;
  endtask

  function automatic logic [15:0] rand_part(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(16)) - 8);
      2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    int kind;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    set_mode(1, 4);
    set_mode(0, 4);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 3; j++) put_sample(edge_vals[i], edge_vals[(i + j * 3) % 8]);
    while (sent < NUM_SAMPLES) begin
      case ((sent / 150) % 4)
        0: begin snd_idle = 0;  rcv_idle = 0;  end
        1: begin snd_idle = 57; rcv_idle = 0;  end
        2: begin snd_idle = 0;  rcv_idle = 57; end
        default: begin snd_idle = 9; rcv_idle = 9; end
      endcase
      // first frame: mode flips mid-frame, the last setting (inverse) wins
      if (sent == 300) set_mode(1, 4);
      if (sent == 700) set_mode(0, 4);
      if (sent == 900) set_mode(1, 4);
      if (sent == 1100) set_mode(0, 4);
      if (sent == 1600) set_mode(1, 4);
      kind = ($urandom_range(9) < 5) ? 0 : $urandom_range(3);
      put_sample(rand_part(kind), rand_part(kind));
    end
    s_tvalid <= 0;
    wait (bins_pending == 0);
    repeat (XFORM_WAIT / 100) @(posedge clk_i);
    if (fail_cnt == 0 && bins_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
